/* rtl/lfp_pkg.sv */
package lfp_pkg;

	localparam int WORD_W   = 24;
	localparam int MARKER_W = 8;
	localparam int CFG_W    = 16;

	localparam logic [MARKER_W-1:0] MARK_THRESHOLD_RST = 8'd200;

	typedef enum logic [2:0] {
		FUNC_LOAD       = 3'd0,
		FUNC_START      = 3'd1,
		FUNC_STOP_REQ   = 3'd2,
		FUNC_STOP_NOW   = 3'd3,
		FUNC_RESET_BUF  = 3'd4,
		FUNC_TICK       = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_READY   = 2'd1,
		MODE_PLAYING = 2'd2
	} mode_t;

	typedef enum logic {
		CFG_MARK_THRESHOLD = 1'b0,
		CFG_BIAS_CODE      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]          func;
		logic [WORD_W-1:0]   load_word0;
		logic [WORD_W-1:0]   load_word1;
		logic [WORD_W-1:0]   load_word2;
		logic [WORD_W-1:0]   load_word3;
		logic [MARKER_W-1:0] load_marker;
	} in_item_t;

	typedef struct packed {
		logic                accepted;
		logic [1:0]          player_state;
		logic [8:0]          frame_count;
		logic [7:0]          play_position;
		logic                frame_valid;
		logic [WORD_W-1:0]   out_word0;
		logic [WORD_W-1:0]   out_word1;
		logic [WORD_W-1:0]   out_word2;
		logic [WORD_W-1:0]   out_word3;
		logic                mark_pin;
		logic                enable_pin;
		logic                park_strobe;
	} out_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]   word0;
		logic [WORD_W-1:0]   word1;
		logic [WORD_W-1:0]   word2;
		logic [WORD_W-1:0]   word3;
		logic [MARKER_W-1:0] marker;
	} frame_t;

	typedef struct packed {
		logic accepted;
		logic load_ok;
		logic start_ok;
		logic halt;
		logic emit;
	} ctrl_t;

endpackage

/* rtl/looping_frame_player_core.sv */
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------
// input    | in_valid  | in_stall  | in_data  (in_item_t)
// output   | out_valid | out_stall | out_data (out_item_t)
// config   | cfg_wr_en | -         | cfg_index, cfg_wdata
//
// One transaction per cycle in and out while neither stall is raised; each
// result passes the synchronous frame store read and the output register.
// Control state (mode, count, position, pending stop) updates on acceptance;
// the mark level updates when the transaction leaves the read stage.
// in_stall rises only when the read stage and the output register are both full
// and out_stall is high. The frame store has no reset.
module looping_frame_player_core
	import lfp_pkg::*;
#(
	parameter int FRAME_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(FRAME_DEPTH + 1);
	localparam int IW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

	frame_t          mem [FRAME_DEPTH];

	mode_t           mode_q, mode_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [IW-1:0]   idx_q, idx_d, rd_idx;
	logic [CW-1:0]   idx_inc;
	logic            pend_q, pend_d;
	logic            en_q, en_d;
	logic            mark_q;
	logic [MARKER_W-1:0] thr_q;
	ctrl_t           ctrl;
	func_t           func;
	frame_t          wr_frame;
	logic            in_acc;

	logic            s1_valid_q;
	logic            s1_adv;
	ctrl_t           ctrl_s1;
	mode_t           mode_s1;
	logic [CW-1:0]   cnt_s1;
	logic [IW-1:0]   idx_s1;
	logic            en_s1;
	frame_t          rd_data_s1;
	logic            mark_s1;
	logic [31:0]     cnt_ext;
	logic [31:0]     idx_ext;

	logic            out_valid_q;
	out_item_t       out_q;
	out_item_t       out_d;

	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign func     = func_t'(in_data.func);

	assign wr_frame = '{word0: in_data.load_word0, word1: in_data.load_word1,
		word2: in_data.load_word2, word3: in_data.load_word3,
		marker: in_data.load_marker};

	always_comb begin
		ctrl     = '{accepted: 1'b1, load_ok: 1'b0, start_ok: 1'b0, halt: 1'b0,
			emit: 1'b0};
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		pend_d   = pend_q;
		en_d     = en_q;
		rd_idx   = idx_q;
		idx_inc  = '0;
		unique case (func)
			FUNC_LOAD: begin
				if (mode_q == MODE_PLAYING || cnt_q >= DEPTH_C) begin
					ctrl.accepted = 1'b0;
				end else begin
					ctrl.load_ok = 1'b1;
					cnt_d        = cnt_q + CW'(1);
				end
			end
			FUNC_START: begin
				if (cnt_q == '0) begin
					ctrl.accepted = 1'b0;
				end else begin
					ctrl.start_ok = 1'b1;
					idx_d         = '0;
					pend_d        = 1'b0;
					en_d          = 1'b1;
				end
			end
			FUNC_STOP_REQ: pend_d = 1'b1;
			FUNC_STOP_NOW: ctrl.halt = 1'b1;
			FUNC_RESET_BUF: begin
				cnt_d     = '0;
				ctrl.halt = 1'b1;
			end
			FUNC_TICK: begin
				if (mode_q == MODE_PLAYING) begin
					if (pend_q || cnt_q == '0) begin
						ctrl.halt = 1'b1;
					end else begin
						ctrl.emit = 1'b1;
						if (CW'(idx_q) >= cnt_q) begin
							rd_idx = '0;
						end
						idx_inc = CW'(rd_idx) + CW'(1);
						idx_d   = (idx_inc >= cnt_q) ? '0 : idx_inc[IW-1:0];
					end
				end
			end
			default: ;
		endcase
		if (ctrl.halt) begin
			pend_d = 1'b0;
			idx_d  = '0;
			en_d   = 1'b0;
		end
	end

	always_comb begin
		priority if (ctrl.halt) begin
			mode_d = (cnt_d != '0) ? MODE_READY : MODE_IDLE;
		end else if (ctrl.load_ok) begin
			mode_d = MODE_READY;
		end else if (ctrl.start_ok) begin
			mode_d = MODE_PLAYING;
		end else begin
			mode_d = mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			idx_q  <= '0;
			pend_q <= 1'b0;
			en_q   <= 1'b0;
		end else if (in_acc) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			idx_q  <= idx_d;
			pend_q <= pend_d;
			en_q   <= en_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= MARK_THRESHOLD_RST;
		end else if (cfg_wr_en && cfg_index == CFG_MARK_THRESHOLD) begin
			thr_q <= cfg_wdata[MARKER_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && ctrl.load_ok) begin
			mem[cnt_q[IW-1:0]] <= wr_frame;
		end
		if (in_acc && ctrl.emit) begin
			rd_data_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctrl_s1 <= ctrl;
			mode_s1 <= mode_d;
			cnt_s1  <= cnt_d;
			idx_s1  <= idx_d;
			en_s1   <= en_d;
		end
	end

	assign cnt_ext = 32'(cnt_s1);
	assign idx_ext = 32'(idx_s1);

	always_comb begin
		priority if (ctrl_s1.emit) begin
			mark_s1 = (rd_data_s1.marker >= thr_q);
		end else if (ctrl_s1.halt) begin
			mark_s1 = 1'b0;
		end else begin
			mark_s1 = mark_q;
		end
		out_d.accepted      = ctrl_s1.accepted;
		out_d.player_state  = mode_s1;
		out_d.frame_count   = cnt_ext[8:0];
		out_d.play_position = idx_ext[7:0];
		out_d.frame_valid   = ctrl_s1.emit;
		out_d.out_word0     = ctrl_s1.emit ? rd_data_s1.word0 : '0;
		out_d.out_word1     = ctrl_s1.emit ? rd_data_s1.word1 : '0;
		out_d.out_word2     = ctrl_s1.emit ? rd_data_s1.word2 : '0;
		out_d.out_word3     = ctrl_s1.emit ? rd_data_s1.word3 : '0;
		out_d.mark_pin      = mark_s1;
		out_d.enable_pin    = en_s1;
		out_d.park_strobe   = ctrl_s1.halt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				mark_q      <= mark_s1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("frame count beyond store depth");

	a_play_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PLAYING |-> (cnt_q != '0 && CW'(idx_q) < cnt_q))
		else $error("play position outside loaded frames");

	a_enable_mode: assert property (@(posedge clk) disable iff (!arst_n)
		en_q == (mode_q == MODE_PLAYING))
		else $error("enable level disagrees with mode");

	a_park_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.park_strobe && out_q.enable_pin))
		else $error("park strobe with enable high");

	a_emit_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && ctrl_s1.emit) |-> mode_s1 == MODE_PLAYING)
		else $error("frame emitted outside playback");
`endif

endmodule
